[src/fas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_pkg: shared constants for the fraction add/subtract/reduce block
// Result field widths, mode codes and status codes.
// ----------------------------------------------------------------------------
package fas_pkg;

	localparam int NUM_BITS = 33;
	localparam int DEN_BITS = 32;

	// Operation selector carried on the input tuser.
	localparam logic MODE_ADD = 1'b0;
	localparam logic MODE_SUB = 1'b1;

	// Status carried on the output tuser.
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_ZERO_DEN = 1'b1;

endpackage

[src/fraction_add_sub_reduce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_add_sub_reduce: signed fraction add/subtract with gcd reduction
// Forms A +/- B by cross multiplication and reduces the result by the gcd.
// ----------------------------------------------------------------------------
// The input item arrives on the s_ stream: tdata holds num_a, den_a, num_b
// and den_b, and tuser selects add or subtract. The result item leaves on
// the m_ stream: tdata holds the reduced numerator and denominator, and
// tuser is the status flag (set when an input denominator is zero, in which
// case both result fields are zero). The denominator keeps its computed sign.
// One item is worked at a time and s_tready is high only while idle. The
// three products share one multiplier, a sum state forms the signed sum,
// the binary gcd runs one subtract or shift per cycle, a shift state
// rebuilds the gcd, and the shared restoring divider runs twice, once for
// the numerator and once for the denominator. A zero denominator skips the
// arithmetic and goes straight to the output state. The result sits in an
// output register, so a stalled receiver does not block the next item from
// being accepted; the block only waits when a second result is ready before
// the first is taken. Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module fraction_add_sub_reduce #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata, from bit 0: num_a, den_a, num_b, den_b, zero padding
	input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
	// s_tuser: mode (0 add, 1 subtract)
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata, from bit 0: res_num (33), res_den (32), zero padding
	output logic [71:0]                          m_tdata,
	// m_tuser: status (0 ok, 1 zero denominator)
	output logic                                 m_tuser
);

	localparam int W  = OPERAND_WIDTH;
	localparam int MW = 2 * W;
	localparam int KW = $clog2(MW + 1);
	localparam int OW = (MW + 1 > fas_pkg::NUM_BITS) ? MW + 1 : fas_pkg::NUM_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_SUM, ST_GCD, ST_SHIFT, ST_DIVN, ST_DIVD, ST_DONE
	} state_t;

	state_t        state_q;
	logic [1:0]    step_q;
	logic          sub_q;
	logic [W-1:0]  na_q, da_q, nb_q, db_q;
	logic          na_neg_q, da_neg_q, nb_neg_q, db_neg_q;
	logic [MW-1:0] p1_q, p2_q, den_mag_q, num_mag_q;
	logic          num_neg_q;
	logic [MW-1:0] ga_q, gb_q, g_q, qnum_q, qden_q;
	logic [KW-1:0] k_q;
	logic          err_q;
	logic          div_start_q;
	logic          m_tvalid_q;
	logic [71:0]   m_tdata_q;
	logic          m_tuser_q;

	// Input field views and magnitudes.
	logic [W-1:0] in_na, in_da, in_nb, in_db;
	assign in_na = s_tdata[W-1:0];
	assign in_da = s_tdata[2*W-1:W];
	assign in_nb = s_tdata[3*W-1:2*W];
	assign in_db = s_tdata[4*W-1:3*W];

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
		mag_of = x[W-1] ? (~x + 1'b1) : x;
	endfunction

	// Shared multiplier.
	logic [W-1:0]  mul_x, mul_y;
	logic [MW-1:0] mul_p;
	always_comb begin
		unique case (step_q)
			2'd0:    begin mul_x = na_q; mul_y = db_q; end
			2'd1:    begin mul_x = nb_q; mul_y = da_q; end
			default: begin mul_x = da_q; mul_y = db_q; end
		endcase
	end
	assign mul_p = MW'(mul_x) * MW'(mul_y);

	// Signed combination of the two cross products.
	logic          t1_neg, t2_neg;
	logic [MW:0]   t1, t2, sum;
	assign t1_neg = na_neg_q ^ db_neg_q;
	assign t2_neg = nb_neg_q ^ da_neg_q ^ (sub_q == fas_pkg::MODE_SUB);
	assign t1     = t1_neg ? -{1'b0, p1_q} : {1'b0, p1_q};
	assign t2     = t2_neg ? -{1'b0, p2_q} : {1'b0, p2_q};
	assign sum    = t1 + t2;

	// Divider, shared by the numerator and denominator divisions.
	logic          div_done;
	logic [MW-1:0] div_quo;
	logic [MW-1:0] div_dividend;
	assign div_dividend = (state_q == ST_DIVD) ? den_mag_q : num_mag_q;

	fas_div #(
		.WIDTH(MW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dividend),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Result formatting: sign-magnitude to wrapped two's complement.
	logic [OW-1:0] num_ext, den_ext, num_out, den_out;
	assign num_ext = OW'(qnum_q);
	assign den_ext = OW'(qden_q);
	assign num_out = num_neg_q ? -num_ext : num_ext;
	assign den_out = (da_neg_q ^ db_neg_q) ? -den_ext : den_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			err_q       <= fas_pkg::STATUS_OK;
			div_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						step_q <= '0;
						if (in_da == '0 || in_db == '0) begin
							err_q   <= fas_pkg::STATUS_ZERO_DEN;
							state_q <= ST_DONE;
						end else begin
							err_q   <= fas_pkg::STATUS_OK;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd2) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_GCD;
				end
				ST_GCD: begin
					if (ga_q == '0 || gb_q == '0) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					div_start_q <= 1'b1;
					state_q     <= ST_DIVN;
				end
				ST_DIVN: begin
					if (div_done) begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIVD;
					end
				end
				ST_DIVD: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sub_q    <= s_tuser;
				na_q     <= mag_of(in_na);
				da_q     <= mag_of(in_da);
				nb_q     <= mag_of(in_nb);
				db_q     <= mag_of(in_db);
				na_neg_q <= in_na[W-1];
				da_neg_q <= in_da[W-1];
				nb_neg_q <= in_nb[W-1];
				db_neg_q <= in_db[W-1];
			end
			ST_MUL: begin
				unique case (step_q)
					2'd0:    p1_q      <= mul_p;
					2'd1:    p2_q      <= mul_p;
					default: den_mag_q <= mul_p;
				endcase
			end
			ST_SUM: begin
				num_neg_q <= sum[MW];
				num_mag_q <= sum[MW] ? MW'(-sum) : sum[MW-1:0];
				ga_q      <= sum[MW] ? MW'(-sum) : sum[MW-1:0];
				gb_q      <= den_mag_q;
				k_q       <= '0;
			end
			ST_GCD: begin
				// Binary gcd: one shift or one subtract per cycle.
				priority if (ga_q == '0 || gb_q == '0) begin
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					k_q  <= k_q + 1'b1;
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q >= gb_q) begin
					ga_q <= ga_q - gb_q;
				end else begin
					gb_q <= gb_q - ga_q;
				end
			end
			ST_SHIFT: begin
				g_q <= (ga_q | gb_q) << k_q;
			end
			ST_DIVN: begin
				if (div_done) begin
					qnum_q <= div_quo;
				end
			end
			ST_DIVD: begin
				if (div_done) begin
					qden_q <= div_quo;
				end
			end
			ST_DONE: begin
				// The output register only changes once the previous result is taken.
				if (!m_tvalid_q || m_tready) begin
					m_tuser_q <= err_q;
					if (err_q == fas_pkg::STATUS_ZERO_DEN) begin
						m_tdata_q <= '0;
					end else begin
						m_tdata_q <= {7'd0, den_out[fas_pkg::DEN_BITS-1:0],
							num_out[fas_pkg::NUM_BITS-1:0]};
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[src/fas_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_div: restoring unsigned divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module fas_div #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient
);

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0] rem_sh;
	logic           fits;

	assign rem_sh = {rem_q, quo_q[WIDTH-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so WIDTH bits hold it.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? WIDTH'(rem_sh - {1'b0, dsr_q}) : rem_sh[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
